### hdl/lgov_pkg.sv
`default_nettype none
package lgov_pkg;

	localparam int unsigned LoadW  = 7;
	localparam int unsigned LevelW = 3;
	localparam int unsigned CountW = 8;
	localparam int unsigned DataW  = 32;
	localparam int unsigned AddrW  = 5;
	localparam int unsigned IndexW = 3;

	localparam logic [LevelW-1:0] LVL_TOP      = 3'd6;
	localparam logic [LevelW-1:0] LVL_MID      = 3'd4;
	localparam logic [LevelW-1:0] LVL_LOW_STEP = 3'd2;
	localparam logic [CountW-1:0] COUNT_MAX    = 8'hFF;

	typedef enum logic [1:0] {
		CHG_NONE = 2'd0,
		CHG_UP   = 2'd1,
		CHG_DOWN = 2'd2
	} change_t;

	typedef enum logic [IndexW-1:0] {
		REG_UPPER_THRESHOLD   = 3'd0,
		REG_LOWER_THRESHOLD   = 3'd1,
		REG_MIN_LEVEL         = 3'd2,
		REG_ABOVE_COUNT_LIMIT = 3'd3,
		REG_BELOW_COUNT_LIMIT = 3'd4,
		REG_BELOW_RUN_LIMIT   = 3'd5
	} reg_index_t;

	typedef struct packed {
		logic [LoadW-1:0]  upper_threshold;
		logic [LoadW-1:0]  lower_threshold;
		logic [LevelW-1:0] min_level;
		logic [CountW-1:0] above_count_limit;
		logic [CountW-1:0] below_count_limit;
		logic [CountW-1:0] below_run_limit;
	} cfg_t;

	function automatic logic [LevelW-1:0] clamp_level(input logic [LevelW-1:0] v);
		clamp_level = (v > LVL_TOP) ? LVL_TOP : v;
	endfunction

	function automatic logic [CountW-1:0] sat_inc(input logic [CountW-1:0] c);
		sat_inc = (c == COUNT_MAX) ? c : c + 8'd1;
	endfunction

endpackage
`default_nettype wire

### hdl/lgov_regs.sv
`default_nettype none
module lgov_regs
	import lgov_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             psel,
	input  wire logic             penable,
	input  wire logic             pwrite,
	input  wire logic [AddrW-1:0] paddr,
	input  wire logic [DataW-1:0] pwdata,
	output logic      [DataW-1:0] prdata,
	output logic                  pready,
	output cfg_t                  cfg
);

	cfg_t               cfg_q;
	logic [IndexW-1:0]  index;
	logic               wr_en;

	assign index  = paddr[AddrW-1:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.upper_threshold   <= 7'd80;
			cfg_q.lower_threshold   <= 7'd40;
			cfg_q.min_level         <= 3'd0;
			cfg_q.above_count_limit <= 8'd2;
			cfg_q.below_count_limit <= 8'd30;
			cfg_q.below_run_limit   <= 8'd10;
		end else if (wr_en) begin
			case (index)
				REG_UPPER_THRESHOLD:   cfg_q.upper_threshold   <= pwdata[LoadW-1:0];
				REG_LOWER_THRESHOLD:   cfg_q.lower_threshold   <= pwdata[LoadW-1:0];
				REG_MIN_LEVEL:         cfg_q.min_level         <= pwdata[LevelW-1:0];
				REG_ABOVE_COUNT_LIMIT: cfg_q.above_count_limit <= pwdata[CountW-1:0];
				REG_BELOW_COUNT_LIMIT: cfg_q.below_count_limit <= pwdata[CountW-1:0];
				REG_BELOW_RUN_LIMIT:   cfg_q.below_run_limit   <= pwdata[CountW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (index)
			REG_UPPER_THRESHOLD:   prdata = {{(DataW-LoadW){1'b0}}, cfg_q.upper_threshold};
			REG_LOWER_THRESHOLD:   prdata = {{(DataW-LoadW){1'b0}}, cfg_q.lower_threshold};
			REG_MIN_LEVEL:         prdata = {{(DataW-LevelW){1'b0}}, cfg_q.min_level};
			REG_ABOVE_COUNT_LIMIT: prdata = {{(DataW-CountW){1'b0}}, cfg_q.above_count_limit};
			REG_BELOW_COUNT_LIMIT: prdata = {{(DataW-CountW){1'b0}}, cfg_q.below_count_limit};
			REG_BELOW_RUN_LIMIT:   prdata = {{(DataW-CountW){1'b0}}, cfg_q.below_run_limit};
			default:               prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

### hdl/lgov_core.sv
`default_nettype none
module lgov_core
	import lgov_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              step,
	input  wire cfg_t              cfg,
	input  wire logic [LoadW-1:0]  cpu_load,
	input  wire logic [LevelW-1:0] current_level,
	input  wire logic [LevelW-1:0] floor_level,
	output change_t                change,
	output logic      [LevelW-1:0] new_level
);

	logic [CountW-1:0] above_count_q, below_count_q;
	logic              downscaling_q;

	logic [CountW-1:0] above_nx, below_nx, above_d, below_d, limit;
	logic              down_nx, down_d, is_above, is_below;
	logic [LevelW-1:0] cur, flr, minl;

	always_comb begin
		cur      = clamp_level(current_level);
		flr      = clamp_level(floor_level);
		minl     = clamp_level(cfg.min_level);
		is_above = (cpu_load > cfg.upper_threshold) && (cur < LVL_TOP);
		is_below = (cpu_load < cfg.lower_threshold) && (cur > minl);
		above_nx = is_above ? sat_inc(above_count_q) : '0;
		below_nx = (!is_above && is_below) ? sat_inc(below_count_q) : '0;
		down_nx  = (below_nx == '0) ? 1'b0 : downscaling_q;
		limit    = down_nx ? cfg.below_run_limit : cfg.below_count_limit;

		above_d   = above_nx;
		below_d   = below_nx;
		down_d    = down_nx;
		change    = CHG_NONE;
		new_level = cur;

		priority if (flr > cur) begin
		end else if (above_nx >= cfg.above_count_limit) begin
			above_d   = '0;
			below_d   = '0;
			change    = CHG_UP;
			new_level = (cur < LVL_MID) ? LVL_MID : LVL_TOP;
		end else if (below_nx >= limit && cur > flr) begin
			above_d   = '0;
			below_d   = '0;
			down_d    = 1'b1;
			change    = CHG_DOWN;
			new_level = (cur <= LVL_LOW_STEP) ? minl : cur - 3'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			above_count_q <= '0;
			below_count_q <= '0;
			downscaling_q <= 1'b0;
		end else if (step) begin
			above_count_q <= above_d;
			below_count_q <= below_d;
			downscaling_q <= down_d;
		end
	end

endmodule
`default_nettype wire

### hdl/load_threshold_frequency_governor_unit.sv
// Load-threshold frequency governor.
// Sample channel: sample_valid / sample_stall carry one word per tick
// (cpu_load, current_level, floor_level). Result channel: result_valid /
// result_stall carry one word per sample (change, new_level).
// A word moves at a rising edge with valid high and stall low.
// An accepted sample passes one input register and one result register,
// with the governor logic between them, before result_valid rises.
// Throughput: one sample per cycle while the result side is not stalled;
// the above/below counters update as a sample leaves the input register,
// so back-to-back samples see each other's effect.
// A stalled result holds in the result register; the input register still
// drains into it once it empties, and sample_stall rises only when both
// registers are full and result_stall is high.
// Reset clears both registers' valid flags, the counters, the downscaling
// flag and loads the default thresholds and limits. Write the APB registers
// only while no sample is in flight.
`default_nettype none
module load_threshold_frequency_governor_unit
	import lgov_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [AddrW-1:0]  paddr,
	input  wire logic [DataW-1:0]  pwdata,
	output logic      [DataW-1:0]  prdata,
	output logic                   pready,
	input  wire logic              sample_valid,
	output logic                   sample_stall,
	input  wire logic [LoadW-1:0]  cpu_load,
	input  wire logic [LevelW-1:0] current_level,
	input  wire logic [LevelW-1:0] floor_level,
	output logic                   result_valid,
	input  wire logic              result_stall,
	output logic      [1:0]        change,
	output logic      [LevelW-1:0] new_level
);

	cfg_t              cfg;
	logic              valid_s1, valid_s2;
	logic [LoadW-1:0]  load_s1;
	logic [LevelW-1:0] cur_s1, floor_s1, level_s2, level_c;
	change_t           change_s2, change_c;
	logic              move_s2, move_s1;

	lgov_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	lgov_core u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (move_s2),
		.cfg           (cfg),
		.cpu_load      (load_s1),
		.current_level (cur_s1),
		.floor_level   (floor_s1),
		.change        (change_c),
		.new_level     (level_c)
	);

	assign move_s2      = valid_s1 && (!valid_s2 || !result_stall);
	assign sample_stall = valid_s1 && !move_s2;
	assign move_s1      = sample_valid && !sample_stall;

	assign result_valid = valid_s2;
	assign change       = change_s2;
	assign new_level    = level_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (move_s1) begin
				valid_s1 <= 1'b1;
			end else if (move_s2) begin
				valid_s1 <= 1'b0;
			end
			if (move_s2) begin
				valid_s2 <= 1'b1;
			end else if (!result_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			load_s1  <= cpu_load;
			cur_s1   <= current_level;
			floor_s1 <= floor_level;
		end
		if (move_s2) begin
			change_s2 <= change_c;
			level_s2  <= level_c;
		end
	end

endmodule
`default_nettype wire

### hdl/lgov_checker.sv
`default_nettype none
module lgov_checker
	import lgov_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              sample_valid,
	input wire logic              sample_stall,
	input wire logic              result_valid,
	input wire logic              result_stall,
	input wire logic [1:0]        change,
	input wire logic [LevelW-1:0] new_level
);

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=>
			result_valid && $stable(change) && $stable(new_level))
		else $error("stalled result word changed");

	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> result_valid && result_stall)
		else $error("sample stall without a stalled result");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> new_level <= LVL_TOP && change != 2'd3)
		else $error("result word out of range");

	a_up_target: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && change == CHG_UP |-> new_level == LVL_MID || new_level == LVL_TOP)
		else $error("upscale to an unexpected level");

endmodule

bind load_threshold_frequency_governor_unit lgov_checker u_lgov_checker (.*);
`default_nettype wire

### dv/tb_load_threshold_frequency_governor_unit.sv
`timescale 1ns / 1ps
module tb_load_threshold_frequency_governor_unit;
	import lgov_pkg::*;

	localparam int unsigned CycleLimit = 400000;

	typedef struct packed {
		change_t           chg;
		logic [LevelW-1:0] lvl;
	} verdict_t;

	class governor_scoreboard;
		logic [LoadW-1:0]  upper;
		logic [LoadW-1:0]  lower;
		logic [LevelW-1:0] min_lvl;
		logic [CountW-1:0] above_lim;
		logic [CountW-1:0] below_lim;
		logic [CountW-1:0] run_lim;
		logic [CountW-1:0] above_cnt;
		logic [CountW-1:0] below_cnt;
		bit                stepping;
		logic [LevelW-1:0] level_hint;
		int unsigned       errors;
		verdict_t          pending_verdicts[$];

		function new();
			upper = 7'd80;
			lower = 7'd40;
			min_lvl = 3'd0;
			above_lim = 8'd2;
			below_lim = 8'd30;
			run_lim = 8'd10;
			above_cnt = '0;
			below_cnt = '0;
			stepping = 1'b0;
			level_hint = '0;
			errors = 0;
		endfunction

		function logic [LevelW-1:0] cap_level(logic [LevelW-1:0] v);
			return (v > LVL_TOP) ? LVL_TOP : v;
		endfunction

		function logic [CountW-1:0] bump(logic [CountW-1:0] c);
			return (c == COUNT_MAX) ? c : c + 8'd1;
		endfunction

		function void set_reg(reg_index_t idx, logic [DataW-1:0] v);
			case (idx)
				REG_UPPER_THRESHOLD:   upper = v[LoadW-1:0];
				REG_LOWER_THRESHOLD:   lower = v[LoadW-1:0];
				REG_MIN_LEVEL:         min_lvl = v[LevelW-1:0];
				REG_ABOVE_COUNT_LIMIT: above_lim = v[CountW-1:0];
				REG_BELOW_COUNT_LIMIT: below_lim = v[CountW-1:0];
				REG_BELOW_RUN_LIMIT:   run_lim = v[CountW-1:0];
				default: ;
			endcase
		endfunction

		function void note_sample(logic [LoadW-1:0] load, logic [LevelW-1:0] cur_in,
				logic [LevelW-1:0] flr_in);
			logic [LevelW-1:0] cur;
			logic [LevelW-1:0] flr;
			logic [LevelW-1:0] minl;
			logic [CountW-1:0] lim;
			verdict_t          v;
			cur = cap_level(cur_in);
			flr = cap_level(flr_in);
			minl = cap_level(min_lvl);
			v.chg = CHG_NONE;
			v.lvl = cur;
			if (load > upper && cur < LVL_TOP) begin
				above_cnt = bump(above_cnt);
				below_cnt = '0;
			end else if (load < lower && cur > minl) begin
				below_cnt = bump(below_cnt);
				above_cnt = '0;
			end else begin
				above_cnt = '0;
				below_cnt = '0;
			end
			if (below_cnt == '0)
				stepping = 1'b0;
			if (flr > cur) begin
				// floor holds the level
			end else if (above_cnt >= above_lim) begin
				above_cnt = '0;
				below_cnt = '0;
				v.chg = CHG_UP;
				v.lvl = (cur < LVL_MID) ? LVL_MID : LVL_TOP;
			end else begin
				lim = stepping ? run_lim : below_lim;
				if (below_cnt >= lim && cur > flr) begin
					stepping = 1'b1;
					above_cnt = '0;
					below_cnt = '0;
					v.chg = CHG_DOWN;
					v.lvl = (cur <= LVL_LOW_STEP) ? minl : cur - 3'd1;
				end
			end
			level_hint = v.lvl;
			pending_verdicts.push_back(v);
		endfunction

		function void check_result(logic [1:0] chg, logic [LevelW-1:0] lvl);
			verdict_t v;
			if (pending_verdicts.size() == 0) begin
				$display("%0t: unexpected result word: change %0d new_level %0d",
					$time, chg, lvl);
				errors++;
				return;
			end
			v = pending_verdicts.pop_front();
			if (chg !== v.chg) begin
				$display("%0t: change mismatch: expected %0d actual %0d", $time, v.chg, chg);
				errors++;
			end
			if (lvl !== v.lvl) begin
				$display("%0t: new_level mismatch: expected %0d actual %0d",
					$time, v.lvl, lvl);
				errors++;
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [AddrW-1:0]  paddr;
	logic [DataW-1:0]  pwdata;
	logic [DataW-1:0]  prdata;
	logic              pready;
	logic              sample_valid;
	logic              sample_stall;
	logic [LoadW-1:0]  cpu_load;
	logic [LevelW-1:0] current_level;
	logic [LevelW-1:0] floor_level;
	logic              result_valid;
	logic              result_stall;
	logic [1:0]        change;
	logic [LevelW-1:0] new_level;

	governor_scoreboard sb;
	bit                 no_idle;
	int unsigned        samples_sent;
	int unsigned        cycles;

	load_threshold_frequency_governor_unit DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.cpu_load     (cpu_load),
		.current_level(current_level),
		.floor_level  (floor_level),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.change       (change),
		.new_level    (new_level)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic write_reg(input reg_index_t idx, input logic [DataW-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.set_reg(idx, value);
	endtask

	task automatic set_config(input int unsigned up, input int unsigned lo,
			input int unsigned ml, input int unsigned al, input int unsigned bl,
			input int unsigned rl);
		write_reg(REG_UPPER_THRESHOLD, up);
		write_reg(REG_LOWER_THRESHOLD, lo);
		write_reg(REG_MIN_LEVEL, ml);
		write_reg(REG_ABOVE_COUNT_LIMIT, al);
		write_reg(REG_BELOW_COUNT_LIMIT, bl);
		write_reg(REG_BELOW_RUN_LIMIT, rl);
	endtask

	task automatic send_sample(input logic [LoadW-1:0] load, input logic [LevelW-1:0] lvl,
			input logic [LevelW-1:0] flr);
		int unsigned gap;
		if ($urandom_range(0, 29) == 0)
			no_idle = !no_idle;
		gap = no_idle ? 0 : $urandom_range(0, 8);
		if (gap != 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1'b1;
		cpu_load <= load;
		current_level <= lvl;
		floor_level <= flr;
		@(posedge clk);
		while (sample_stall) @(posedge clk);
		sb.note_sample(load, lvl, flr);
		samples_sent++;
	endtask

	task automatic close_phase();
		sample_valid <= 1'b0;
		while (sb.pending_verdicts.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_sequences(input int unsigned budget);
		int unsigned       goal;
		int unsigned       kind;
		int unsigned       len;
		int unsigned       r;
		logic [LoadW-1:0]  load;
		logic [LevelW-1:0] lvl;
		logic [LevelW-1:0] flr;
		goal = samples_sent + budget;
		while (samples_sent < goal) begin
			kind = $urandom_range(0, 9);
			len = (kind < 4) ? $urandom_range(1, 12) :
				(kind < 8) ? $urandom_range(1, 40) : $urandom_range(1, 6);
			repeat (len) begin
				if (kind < 4)
					load = (sb.upper >= 7'd127) ? 7'($urandom) :
						7'($urandom_range(127, sb.upper + 1));
				else if (kind < 8)
					load = (sb.lower == 7'd0) ? 7'($urandom) :
						7'($urandom_range(sb.lower - 1, 0));
				else
					load = 7'($urandom);
				lvl = ($urandom_range(0, 15) == 0 || kind == 9) ? 3'($urandom) : sb.level_hint;
				r = $urandom_range(0, 9);
				if (r < 5)
					flr = 3'($urandom_range(0, sb.cap_level(lvl)));
				else if (r < 8)
					flr = 3'd0;
				else
					flr = 3'($urandom);
				send_sample(load, lvl, flr);
			end
		end
	endtask

	initial begin
		int unsigned up;
		int unsigned lo;
		int unsigned al;
		int unsigned bl;
		int unsigned rl;
		sb = new();
		no_idle = 1'b0;
		samples_sent = 0;
		cycles = 0;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		sample_valid <= 1'b0;
		cpu_load <= '0;
		current_level <= '0;
		floor_level <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_config(50, 30, 1, 1, 2, 1);
		send_sample(7'd100, 3'd2, 3'd0);
		send_sample(7'd127, 3'd4, 3'd0);
		send_sample(7'd127, 3'd7, 3'd7);
		send_sample(7'd0, 3'd6, 3'd7);
		send_sample(7'd0, 3'd6, 3'd0);
		send_sample(7'd0, 3'd5, 3'd0);
		send_sample(7'd0, 3'd4, 3'd0);
		send_sample(7'd0, 3'd3, 3'd0);
		send_sample(7'd0, 3'd2, 3'd0);
		send_sample(7'd0, 3'd1, 3'd0);
		send_sample(7'd100, 3'd2, 3'd5);
		send_sample(7'd100, 3'd2, 3'd5);
		send_sample(7'd50, 3'd3, 3'd0);
		send_sample(7'd30, 3'd3, 3'd0);
		send_sample(7'd29, 3'd3, 3'd3);
		send_sample(7'd29, 3'd3, 3'd3);
		send_sample(7'd29, 3'd3, 3'd2);
		send_sample(7'd0, 3'd7, 3'd0);
		send_sample(7'd101, 3'd0, 3'd0);
		send_sample(7'd85, 3'd5, 3'd2);
		close_phase();

		for (int ph = 0; ph < 10; ph++) begin
			case (ph)
				0: set_config(80, 40, 0, 2, 30, 10);
				1: set_config(0, 0, 0, 0, 0, 0);
				2: set_config(100, 100, 0, 255, 255, 255);
				3: set_config(100, 0, 7, 0, 255, 0);
				default: begin
					up = $urandom_range(0, 100);
					lo = $urandom_range(0, 100);
					al = ($urandom_range(0, 7) == 0) ? 255 : $urandom_range(0, 6);
					bl = ($urandom_range(0, 7) == 0) ? 255 : $urandom_range(0, 12);
					rl = ($urandom_range(0, 7) == 0) ? 255 : $urandom_range(0, 6);
					set_config(up, lo, $urandom_range(0, 7), al, bl, rl);
				end
			endcase
			if (ph == 2) begin
				// saturate each counter behind the floor, then release it
				repeat (264) send_sample(7'd127, 3'd2, 3'd6);
				send_sample(7'd127, 3'd2, 3'd0);
				repeat (264) send_sample(7'd0, 3'd3, 3'd3);
				send_sample(7'd0, 3'd3, 3'd0);
			end
			run_sequences(60);
			close_phase();
		end

		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.pending_verdicts.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	initial begin
		int unsigned hold;
		result_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			hold = no_idle ? 0 : $urandom_range(0, 8);
			if (hold != 0) begin
				result_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				result_stall <= 1'b0;
			end
			@(posedge clk);
			while (!result_valid) @(posedge clk);
			sb.check_result(change, new_level);
		end
	end

endmodule
